FILE: hdl/tpc_pkg.sv
package tpc_pkg;

   // Default width of the coordinate part of each input field.
   localparam int COORD_WIDTH_DEFAULT = 32;

   // Point dimension codes carried in the command field.
   localparam logic CMD_PLANAR  = 1'b0;
   localparam logic CMD_SPATIAL = 1'b1;

   // The quotient is scaled by 2^33 (factor two and Q16.16 result scaling).
   localparam int NUM_SHIFT = 33;
   // Quotient bits below the saturation bit.
   localparam int QUOT_BITS = 31;

   // Result limits for saturation.
   localparam logic [31:0] CURV_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] CURV_MIN = 32'h8000_0000;

   // One point triple.
   typedef struct packed {
      logic               command;
      logic signed [31:0] first_x;
      logic signed [31:0] first_y;
      logic signed [31:0] first_z;
      logic signed [31:0] middle_x;
      logic signed [31:0] middle_y;
      logic signed [31:0] middle_z;
      logic signed [31:0] last_x;
      logic signed [31:0] last_y;
      logic signed [31:0] last_z;
   } req_type;

   // One curvature result.
   typedef struct packed {
      logic signed [31:0] curvature;
      logic               degenerate;
   } rsp_type;

endpackage

FILE: hdl/three_point_curvature_core.sv
// Signed curvature of the quadratic through three points, 2D or 3D, in Q16.16.
// The core is a fully pipelined datapath: it takes one point triple in every cycle while
// the result side does not stall. The pipeline depth is set by the square root of the 3D
// cross product, which resolves one root bit per stage over 2*COORD_WIDTH+2 stages,
// and by the stages of the restoring divider that forms the quotient. A stall on the result
// side while a result is waiting holds the whole pipeline and the input stall rises with it.
// Coincident points give zero with the degenerate flag set; results out of range
// saturate.
module three_point_curvature_core
   import tpc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int W    = COORD_WIDTH;
   localparam int DW1  = W + 1;          // coordinate differences
   localparam int H    = W + 1;          // split width for partial products, root width
   localparam int H2   = 2 * H;
   localparam int PW   = 2 * W + 2;      // products of differences
   localparam int CCW  = 2 * W + 3;      // signed cross components
   localparam int CW   = 2 * H;          // cross magnitude and its root
   localparam int XW   = 4 * H;          // radicand width
   localparam int PSW  = W + 2;          // s + u
   localparam int P2W  = 2 * W + 4;      // (s + u)^2
   localparam int NW   = CW + P2W;       // numerator
   localparam int W3W  = 3 * H;          // w^3
   localparam int DNW  = 5 * H;          // denominator
   localparam int RMW  = ((NW + NUM_SHIFT > DNW + QUOT_BITS) ?
                          NW + NUM_SHIFT : DNW + QUOT_BITS) + 1;

   typedef struct packed {
      logic                      valid;
      logic                      d3;
      logic [8:0][DW1-1:0]       v;
   } s1_type;

   typedef struct packed {
      logic                      valid;
      logic                      d3;
      logic [8:0][PW-1:0]        sqr;
      logic [5:0][PW-1:0]        crs;
   } s2_type;

   typedef struct packed {
      logic                      valid;
      logic                      d3;
      logic                      neg;
      logic [2:0][PW-1:0]        len;
      logic [2:0][CW-1:0]        mag;
   } s3_type;

   typedef struct packed {
      logic                      valid;
      logic                      d3;
      logic                      neg;
      logic [2:0][PW-1:0]        len;
      logic [CW-1:0]             magz;
      logic [2:0][2:0][H2-1:0]   pp;
   } s4_type;

   typedef struct packed {
      logic                      valid;
      logic                      d3;
      logic                      neg;
      logic [CW-1:0]             magz;
      logic [3:0][XW-1:0]        rem;
      logic [3:0][CW-1:0]        root;
   } sq_type;

   typedef struct packed {
      logic                      valid;
      logic                      neg;
      logic                      deg;
      logic [CW-1:0]             cm;
      logic [P2W-1:0]            p2;
      logic [H2-1:0]             su;
      logic [H2-1:0]             w2;
      logic [H-1:0]              w;
   } m1_type;

   typedef struct packed {
      logic                      valid;
      logic                      neg;
      logic                      deg;
      logic [H2-1:0]             su;
      logic [3:0][P2W-1:0]       pn;
      logic [1:0][H2-1:0]        pw;
   } m2_type;

   typedef struct packed {
      logic                      valid;
      logic                      neg;
      logic                      deg;
      logic [H2-1:0]             su;
      logic [NW-1:0]             num;
      logic [W3W-1:0]            w3;
   } m3_type;

   typedef struct packed {
      logic                      valid;
      logic                      neg;
      logic                      deg;
      logic [NW-1:0]             num;
      logic [5:0][H2-1:0]        pd;
   } m4_type;

   typedef struct packed {
      logic                      valid;
      logic                      neg;
      logic                      deg;
      logic [NW-1:0]             num;
      logic [DNW-1:0]            den;
   } m5_type;

   typedef struct packed {
      logic                      valid;
      logic                      neg;
      logic                      deg;
      logic                      sat;
      logic [QUOT_BITS-1:0]      q;
      logic [DNW-1:0]            den;
      logic [RMW-1:0]            rem;
   } dv_type;

   typedef struct packed {
      logic                      valid;
      rsp_type                   data;
   } out_type;

   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   s3_type  s3_ff, s3_in;
   s4_type  s4_ff, s4_in;
   sq_type  sq_ff [0:CW];
   sq_type  sq0_in;
   sq_type  sq_in [1:CW];
   m1_type  m1_ff, m1_in;
   m2_type  m2_ff, m2_in;
   m3_type  m3_ff, m3_in;
   m4_type  m4_ff, m4_in;
   m5_type  m5_ff, m5_in;
   dv_type  dv_ff [0:QUOT_BITS];
   dv_type  dv0_in;
   dv_type  dv_in [1:QUOT_BITS];
   out_type out_ff, out_in;

   logic                    en;
   logic [31:0]             fld [9];
   logic [W-1:0]            crd [9];

   function automatic logic signed [DW1-1:0] sx(input logic [W-1:0] a);
      return $signed({a[W-1], a});
   endfunction

   function automatic logic signed [PW-1:0] smul(input logic signed [DW1-1:0] a,
                                                 input logic signed [DW1-1:0] b);
      return PW'(a) * PW'(b);
   endfunction

   // The whole pipeline moves unless a finished result is held by the sink.
   assign en        = !out_ff.valid || !rsp_stall;
   assign req_stall = !en;
   assign rsp_valid = out_ff.valid;
   assign rsp_data  = out_ff.data;

   // Coordinate extraction from the low COORD_WIDTH bits of each field, or zero extension of the field above 32.
   assign fld[0] = req_data.first_x;
   assign fld[1] = req_data.first_y;
   assign fld[2] = req_data.first_z;
   assign fld[3] = req_data.middle_x;
   assign fld[4] = req_data.middle_y;
   assign fld[5] = req_data.middle_z;
   assign fld[6] = req_data.last_x;
   assign fld[7] = req_data.last_y;
   assign fld[8] = req_data.last_z;

   generate
      for (genvar g = 0; g < 9; g++) begin : g_crd
         if (COORD_WIDTH <= 32) begin : g_low
            assign crd[g] = fld[g][W-1:0];
         end else begin : g_zext
            assign crd[g] = {{(W - 32){1'b0}}, fld[g]};
         end
      end
   endgenerate

   // Stage 1: vectors from the middle point and the chord between the outer points.
   always_comb begin
      s1_in.valid = req_valid;
      s1_in.d3    = (req_data.command == CMD_SPATIAL);
      s1_in.v[0]  = sx(crd[0]) - sx(crd[3]);
      s1_in.v[1]  = sx(crd[1]) - sx(crd[4]);
      s1_in.v[2]  = s1_in.d3 ? sx(crd[2]) - sx(crd[5]) : '0;
      s1_in.v[3]  = sx(crd[6]) - sx(crd[3]);
      s1_in.v[4]  = sx(crd[7]) - sx(crd[4]);
      s1_in.v[5]  = s1_in.d3 ? sx(crd[8]) - sx(crd[5]) : '0;
      s1_in.v[6]  = sx(crd[0]) - sx(crd[6]);
      s1_in.v[7]  = sx(crd[1]) - sx(crd[7]);
      s1_in.v[8]  = s1_in.d3 ? sx(crd[2]) - sx(crd[8]) : '0;
   end

   // Stage 2: squared components and the cross product terms.
   always_comb begin
      s2_in.valid = s1_ff.valid;
      s2_in.d3    = s1_ff.d3;
      for (int i = 0; i < 9; i++) begin
         s2_in.sqr[i] = smul($signed(s1_ff.v[i]), $signed(s1_ff.v[i]));
      end
      s2_in.crs[0] = smul($signed(s1_ff.v[1]), $signed(s1_ff.v[5]));
      s2_in.crs[1] = smul($signed(s1_ff.v[2]), $signed(s1_ff.v[4]));
      s2_in.crs[2] = smul($signed(s1_ff.v[2]), $signed(s1_ff.v[3]));
      s2_in.crs[3] = smul($signed(s1_ff.v[0]), $signed(s1_ff.v[5]));
      s2_in.crs[4] = smul($signed(s1_ff.v[0]), $signed(s1_ff.v[4]));
      s2_in.crs[5] = smul($signed(s1_ff.v[1]), $signed(s1_ff.v[3]));
   end

   // Stage 3: squared chord lengths and cross product magnitudes.
   always_comb begin
      logic signed [CCW-1:0] c [3];
      s3_in.valid = s2_ff.valid;
      s3_in.d3    = s2_ff.d3;
      for (int j = 0; j < 3; j++) begin
         s3_in.len[j] = s2_ff.sqr[3*j] + s2_ff.sqr[3*j+1] + s2_ff.sqr[3*j+2];
         c[j] = CCW'($signed(s2_ff.crs[2*j])) - CCW'($signed(s2_ff.crs[2*j+1]));
         s3_in.mag[j] = CW'(c[j][CCW-1] ? -c[j] : c[j]);
      end
      s3_in.neg = !s2_ff.d3 && c[2][CCW-1];
   end

   // Stage 4: partial products for the squares of the cross components.
   always_comb begin
      logic [H-1:0] hi;
      logic [H-1:0] lo;
      s4_in.valid = s3_ff.valid;
      s4_in.d3    = s3_ff.d3;
      s4_in.neg   = s3_ff.neg;
      s4_in.len   = s3_ff.len;
      s4_in.magz  = s3_ff.mag[2];
      for (int j = 0; j < 3; j++) begin
         hi = s3_ff.mag[j][CW-1:H];
         lo = s3_ff.mag[j][H-1:0];
         s4_in.pp[j][0] = H2'(hi) * H2'(hi);
         s4_in.pp[j][1] = H2'(hi) * H2'(lo);
         s4_in.pp[j][2] = H2'(lo) * H2'(lo);
      end
   end

   // Stage 5: radicands for the three chord roots and the cross product root.
   always_comb begin
      sq0_in.valid = s4_ff.valid;
      sq0_in.d3    = s4_ff.d3;
      sq0_in.neg   = s4_ff.neg;
      sq0_in.magz  = s4_ff.magz;
      sq0_in.root  = '0;
      for (int j = 0; j < 3; j++) begin
         sq0_in.rem[j] = XW'(s4_ff.len[j]);
      end
      sq0_in.rem[3] = '0;
      for (int j = 0; j < 3; j++) begin
         sq0_in.rem[3] = sq0_in.rem[3] + (XW'(s4_ff.pp[j][0]) << H2)
                         + (XW'(s4_ff.pp[j][1]) << (H + 1)) + XW'(s4_ff.pp[j][2]);
      end
   end

   // Square root stages: each resolves one root bit of all four channels.
   always_comb begin
      logic [XW-1:0] trial;
      for (int k = 0; k < CW; k++) begin
         sq_in[k+1] = sq_ff[k];
         for (int ch = 0; ch < 4; ch++) begin
            trial = (XW'(sq_ff[k].root[ch]) << (CW - k)) | (XW'(1) << (2 * (CW - 1 - k)));
            if (sq_ff[k].rem[ch] >= trial) begin
               sq_in[k+1].rem[ch]           = sq_ff[k].rem[ch] - trial;
               sq_in[k+1].root[ch][CW-1-k]  = 1'b1;
            end
         end
      end
   end

   // Multiply stage 1: (s + u)^2, s * u and w^2.
   always_comb begin
      logic [H-1:0]   rs;
      logic [H-1:0]   ru;
      logic [H-1:0]   rw;
      logic [PSW-1:0] psum;
      rs   = sq_ff[CW].root[0][H-1:0];
      ru   = sq_ff[CW].root[1][H-1:0];
      rw   = sq_ff[CW].root[2][H-1:0];
      psum = PSW'(rs) + PSW'(ru);
      m1_in.valid = sq_ff[CW].valid;
      m1_in.neg   = sq_ff[CW].neg;
      m1_in.deg   = (rs == '0) || (ru == '0) || (rw == '0);
      m1_in.cm    = sq_ff[CW].d3 ? sq_ff[CW].root[3] : sq_ff[CW].magz;
      m1_in.p2    = P2W'(psum) * P2W'(psum);
      m1_in.su    = H2'(rs) * H2'(ru);
      m1_in.w2    = H2'(rw) * H2'(rw);
      m1_in.w     = rw;
   end

   // Multiply stage 2: partial products of |C| (s + u)^2 and of w^3.
   always_comb begin
      logic [H-1:0]     ch;
      logic [H-1:0]     cl;
      logic [P2W-H-1:0] ph;
      logic [H-1:0]     pl;
      ch = m1_ff.cm[CW-1:H];
      cl = m1_ff.cm[H-1:0];
      ph = m1_ff.p2[P2W-1:H];
      pl = m1_ff.p2[H-1:0];
      m2_in.valid = m1_ff.valid;
      m2_in.neg   = m1_ff.neg;
      m2_in.deg   = m1_ff.deg;
      m2_in.su    = m1_ff.su;
      m2_in.pn[0] = P2W'(ch) * P2W'(ph);
      m2_in.pn[1] = P2W'(ch) * P2W'(pl);
      m2_in.pn[2] = P2W'(cl) * P2W'(ph);
      m2_in.pn[3] = P2W'(cl) * P2W'(pl);
      m2_in.pw[0] = H2'(m1_ff.w2[H2-1:H]) * H2'(m1_ff.w);
      m2_in.pw[1] = H2'(m1_ff.w2[H-1:0]) * H2'(m1_ff.w);
   end

   // Multiply stage 3: assemble the numerator and w^3.
   always_comb begin
      m3_in.valid = m2_ff.valid;
      m3_in.neg   = m2_ff.neg;
      m3_in.deg   = m2_ff.deg;
      m3_in.su    = m2_ff.su;
      m3_in.num   = (NW'(m2_ff.pn[0]) << H2)
                    + ((NW'(m2_ff.pn[1]) + NW'(m2_ff.pn[2])) << H) + NW'(m2_ff.pn[3]);
      m3_in.w3    = (W3W'(m2_ff.pw[0]) << H) + W3W'(m2_ff.pw[1]);
   end

   // Multiply stage 4: partial products of s * u * w^3.
   always_comb begin
      m4_in.valid = m3_ff.valid;
      m4_in.neg   = m3_ff.neg;
      m4_in.deg   = m3_ff.deg;
      m4_in.num   = m3_ff.num;
      for (int j = 0; j < 3; j++) begin
         m4_in.pd[j]   = H2'(m3_ff.su[H-1:0]) * H2'(m3_ff.w3[j*H +: H]);
         m4_in.pd[3+j] = H2'(m3_ff.su[H2-1:H]) * H2'(m3_ff.w3[j*H +: H]);
      end
   end

   // Multiply stage 5: assemble the denominator.
   always_comb begin
      m5_in.valid = m4_ff.valid;
      m5_in.neg   = m4_ff.neg;
      m5_in.deg   = m4_ff.deg;
      m5_in.num   = m4_ff.num;
      m5_in.den   = '0;
      for (int j = 0; j < 3; j++) begin
         m5_in.den = m5_in.den + (DNW'(m4_ff.pd[j]) << (j * H))
                     + (DNW'(m4_ff.pd[3+j]) << ((j + 1) * H));
      end
   end

   // Divider entry: scale the numerator and detect an out-of-range quotient.
   always_comb begin
      dv0_in.valid = m5_ff.valid;
      dv0_in.neg   = m5_ff.neg;
      dv0_in.deg   = m5_ff.deg;
      dv0_in.den   = m5_ff.den;
      dv0_in.q     = '0;
      dv0_in.rem   = RMW'(m5_ff.num) << NUM_SHIFT;
      dv0_in.sat   = dv0_in.rem >= (RMW'(m5_ff.den) << QUOT_BITS);
   end

   // Restoring divider: one quotient bit per stage, most significant first.
   always_comb begin
      logic [RMW-1:0] lim;
      for (int k = 0; k < QUOT_BITS; k++) begin
         dv_in[k+1] = dv_ff[k];
         lim = RMW'(dv_ff[k].den) << (QUOT_BITS - 1 - k);
         if (dv_ff[k].rem >= lim) begin
            dv_in[k+1].rem                  = dv_ff[k].rem - lim;
            dv_in[k+1].q[QUOT_BITS-1-k]     = 1'b1;
         end
      end
   end

   // Output stage: sign, saturation and the degenerate case.
   always_comb begin
      logic [31:0] qmag;
      qmag = dv_ff[QUOT_BITS].sat ? CURV_MIN : {1'b0, dv_ff[QUOT_BITS].q};
      out_in.valid = dv_ff[QUOT_BITS].valid;
      if (dv_ff[QUOT_BITS].deg) begin
         out_in.data.curvature  = '0;
         out_in.data.degenerate = 1'b1;
      end else if (dv_ff[QUOT_BITS].neg) begin
         out_in.data.curvature  = $signed(32'd0 - qmag);
         out_in.data.degenerate = 1'b0;
      end else begin
         out_in.data.curvature  = $signed((qmag > CURV_MAX) ? CURV_MAX : qmag);
         out_in.data.degenerate = 1'b0;
      end
   end

   // Pipeline registers; only the valid bits are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid  <= 1'b0;
         s2_ff.valid  <= 1'b0;
         s3_ff.valid  <= 1'b0;
         s4_ff.valid  <= 1'b0;
         for (int k = 0; k <= CW; k++) begin
            sq_ff[k].valid <= 1'b0;
         end
         m1_ff.valid  <= 1'b0;
         m2_ff.valid  <= 1'b0;
         m3_ff.valid  <= 1'b0;
         m4_ff.valid  <= 1'b0;
         m5_ff.valid  <= 1'b0;
         for (int k = 0; k <= QUOT_BITS; k++) begin
            dv_ff[k].valid <= 1'b0;
         end
         out_ff.valid <= 1'b0;
      end else if (en) begin
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         s3_ff    <= s3_in;
         s4_ff    <= s4_in;
         sq_ff[0] <= sq0_in;
         for (int k = 1; k <= CW; k++) begin
            sq_ff[k] <= sq_in[k];
         end
         m1_ff    <= m1_in;
         m2_ff    <= m2_in;
         m3_ff    <= m3_in;
         m4_ff    <= m4_in;
         m5_ff    <= m5_in;
         dv_ff[0] <= dv0_in;
         for (int k = 1; k <= QUOT_BITS; k++) begin
            dv_ff[k] <= dv_in[k];
         end
         out_ff   <= out_in;
      end
   end

   // An accepted triple always occupies the first stage afterwards.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_ff.valid)
      else $error("accepted triple did not enter the pipeline");

   // A degenerate result carries zero curvature.
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.degenerate) |-> (rsp_data.curvature == '0))
      else $error("degenerate result with nonzero curvature");

   // A negative planar cross product has a nonzero magnitude.
   a_sign_magnitude: assert property (@(posedge clock) disable iff (reset)
      (m1_ff.valid && m1_ff.neg) |-> (m1_ff.cm != '0))
      else $error("negative sign on a zero cross product");

   // Nonzero chord lengths give a nonzero denominator at the divider.
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (dv_ff[0].valid && !dv_ff[0].deg) |-> (dv_ff[0].den != '0))
      else $error("zero divisor for a nondegenerate triple");

endmodule

FILE: tb/tb_curvature_checker.sv
module tb_curvature_checker
   import tpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      errors,
   output int      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [319:0] wide_type;
   typedef logic signed [319:0] swide_type;

   rsp_type expected_curvature[$];

   // Floor of the square root; every root here is below 2^128.
   function automatic wide_type floor_root(input wide_type v);
      wide_type r, c;
      r = '0;
      for (int b = 127; b >= 0; b--) begin
         c = r | (wide_type'(1) << b);
         if (c * c <= v) r = c;
      end
      return r;
   endfunction

   function automatic wide_type chord_length(input longint x, input longint y, input longint z);
      swide_type a, b, c;
      a = swide_type'(x);
      b = swide_type'(y);
      c = swide_type'(z);
      return floor_root(wide_type'(a * a + b * b + c * c));
   endfunction

   // Curvature from chord lengths and the cross product of the two arms.
   function automatic rsp_type predict_curvature(input req_type t);
      rsp_type r;
      logic    spatial, neg;
      longint  x0, y0, z0, x2, y2, z2;
      swide_type sx0, sy0, sz0, sx2, sy2, sz2, cx, cy, cz;
      wide_type  s, u, w, cm, su, num, den;
      logic [31:0] q;
      spatial = (t.command == CMD_SPATIAL);
      x0 = longint'(t.first_x) - longint'(t.middle_x);
      y0 = longint'(t.first_y) - longint'(t.middle_y);
      z0 = spatial ? longint'(t.first_z) - longint'(t.middle_z) : longint'(0);
      x2 = longint'(t.last_x) - longint'(t.middle_x);
      y2 = longint'(t.last_y) - longint'(t.middle_y);
      z2 = spatial ? longint'(t.last_z) - longint'(t.middle_z) : longint'(0);
      s = chord_length(x0, y0, z0);
      u = chord_length(x2, y2, z2);
      w = chord_length(x0 - x2, y0 - y2, z0 - z2);
      r.curvature = '0;
      r.degenerate = 1'b1;
      if (s == 0 || u == 0 || w == 0) return r;
      sx0 = swide_type'(x0); sy0 = swide_type'(y0); sz0 = swide_type'(z0);
      sx2 = swide_type'(x2); sy2 = swide_type'(y2); sz2 = swide_type'(z2);
      cx = sy0 * sz2 - sz0 * sy2;
      cy = sz0 * sx2 - sx0 * sz2;
      cz = sx0 * sy2 - sy0 * sx2;
      neg = 1'b0;
      if (spatial) begin
         cm = floor_root(wide_type'(cx * cx + cy * cy + cz * cz));
      end else begin
         neg = (cz < 0);
         cm = wide_type'(neg ? -cz : cz);
      end
      su = s + u;
      num = (cm * su * su) << NUM_SHIFT;
      den = s * u * w * w * w;
      if (num >= (den << QUOT_BITS)) q = CURV_MIN;
      else q = 32'(num / den);
      if (neg) r.curvature = -q;
      else r.curvature = (q > CURV_MAX) ? CURV_MAX : q;
      r.degenerate = 1'b0;
      return r;
   endfunction

   assign pending = expected_curvature.size();

   // Predict on each input transfer and compare each result transfer.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         errors <= 0;
      end else begin
         if (req_valid && !req_stall) expected_curvature.push_back(predict_curvature(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_curvature.size() == 0) begin
               $display("%0t: unexpected result curvature %h degenerate %b", $time,
                        rsp_data.curvature, rsp_data.degenerate);
               errors <= errors + 1;
            end else begin
               want = expected_curvature.pop_front();
               if (want.curvature !== rsp_data.curvature ||
                   want.degenerate !== rsp_data.degenerate) begin
                  $display("%0t: expected curvature %h degenerate %b, got %h %b", $time,
                           want.curvature, want.degenerate,
                           rsp_data.curvature, rsp_data.degenerate);
                  errors <= errors + 1;
               end
            end
         end
      end
   end
endmodule

FILE: tb/tb.sv
module tb;
   import tpc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      errors, pending;
   int      send_idle_pct = 0, recv_idle_pct = 0;
   int      cycles = 0, sent = 0;

   three_point_curvature_core dut (.*);
   tb_curvature_checker checker_i (.*);

   always #1 clock = ~clock;

   // Receiver back-pressure.
   always @(posedge clock) rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   function automatic req_type triple(input logic cmd,
         input int fx, input int fy, input int fz, input int mx, input int my, input int mz,
         input int lx, input int ly, input int lz);
      req_type t;
      t = '{cmd, fx, fy, fz, mx, my, mz, lx, ly, lz};
      return t;
   endfunction

   function automatic int offset(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // Random triples, mostly well-formed with small arms around a random center.
   function automatic req_type random_triple();
      req_type t;
      int kind, span, cx, cy, cz, dx, dy, dz, k;
      kind = $urandom_range(0, 9);
      cx = $urandom; cy = $urandom; cz = $urandom;
      span = (kind < 4) ? (1 << $urandom_range(2, 20)) : 4;
      t.command = 1'($urandom_range(0, 1));
      t.middle_x = cx; t.middle_y = cy; t.middle_z = cz;
      t.first_x = cx + offset(span); t.first_y = cy + offset(span);
      t.first_z = cz + offset(span);
      t.last_x = cx + offset(span); t.last_y = cy + offset(span);
      t.last_z = cz + offset(span);
      case (kind)
         4: t = triple(1'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom);
         5: begin
            t.first_x = cx; t.first_y = cy; t.first_z = cz;
         end
         6: begin
            t.last_x = t.first_x; t.last_y = t.first_y; t.last_z = t.first_z;
         end
         7: begin
            dx = offset(1000); dy = offset(1000); dz = offset(1000);
            k = $urandom_range(1, 50);
            t.first_x = cx - dx; t.first_y = cy - dy; t.first_z = cz - dz;
            t.last_x = cx + k * dx; t.last_y = cy + k * dy; t.last_z = cz + k * dz;
         end
         default: ;
      endcase
      return t;
   endfunction

   // One transfer with a random sender gap in front of it.
   task automatic send(input req_type t);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   initial begin
      req_type directed[$];
      int one;
      one = 65536;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed triples: arcs, coincident points, collinear points, extremes.
      directed.push_back(triple(CMD_PLANAR, -one, 0, 0, 0, one, 0, one, 0, 0));
      directed.push_back(triple(CMD_PLANAR, one, 0, 0, 0, one, 0, -one, 0, 0));
      directed.push_back(triple(CMD_SPATIAL, one, 0, 5, 0, one, 7, -one, 0, 9));
      directed.push_back(triple(CMD_SPATIAL, 0, 0, one, 0, 0, 0, one, 0, 0));
      directed.push_back(triple(CMD_PLANAR, 5, 5, 0, 5, 5, 0, 5, 5, 0));
      directed.push_back(triple(CMD_PLANAR, 3, 4, 0, 3, 4, 0, 9, 9, 0));
      directed.push_back(triple(CMD_PLANAR, 1, 2, 0, 3, 4, 0, 3, 4, 0));
      directed.push_back(triple(CMD_SPATIAL, 1, 2, 3, 7, 7, 7, 1, 2, 3));
      directed.push_back(triple(CMD_PLANAR, 1, 2, -9, 3, 4, 77, 1, 2, 5));
      directed.push_back(triple(CMD_PLANAR, 0, 0, 0, one, one, 0, 3 * one, 3 * one, 0));
      directed.push_back(triple(CMD_SPATIAL, 0, 0, 0, one, one, one, 2 * one, 2 * one, 2 * one));
      directed.push_back(triple(CMD_PLANAR, 0, 0, 0, 1, 0, 0, 1, 1, 0));
      directed.push_back(triple(CMD_PLANAR, 1, 1, 0, 1, 0, 0, 0, 0, 0));
      directed.push_back(triple(CMD_SPATIAL, 0, 0, 0, 0, 0, 1, 1, 0, 1));
      directed.push_back(triple(CMD_PLANAR, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0,
                                32'h80000000, 32'h7FFFFFFF, 0));
      directed.push_back(triple(CMD_SPATIAL, 32'h80000000, 32'h80000000, 32'h80000000,
                                32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                32'h80000000, 32'h7FFFFFFF, 32'h80000000));
      directed.push_back(triple(CMD_SPATIAL, 32'h7FFFFFFF, 0, 32'h80000000, 0, 0, 0,
                                32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF));
      directed.push_back(triple(CMD_PLANAR, -1, -1, -1, -1, 0, -1, 0, 0, -1));
      directed.push_back(triple(CMD_PLANAR, 2 * one, 0, 0, 0, 0, 0, 0, -3 * one, 0));

      send_idle_pct = 19;
      recv_idle_pct = 67;
      foreach (directed[i]) send(directed[i]);
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 67 : 0;
         recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 19 : 0;
         repeat (234) send(random_triple());
      end
      req_valid <= 1'b0;

      // Drain the pipeline, then allow for anything left in flight.
      while (pending != 0) @(posedge clock);
      repeat (250) @(posedge clock);
      $display("tb: %0d point triples sent, 2D and 3D, under three idle patterns", sent);
      $display("tb: covered coincident, collinear, saturating and full-range triples");
      if (errors == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end
endmodule
